[rtl/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg
// Types and constants shared by the polyline curvature estimator modules.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Input item: one polyline point
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } in_t;

  // Result item: segment length and curvature of one point
  typedef struct packed {
    logic        [31:0] segment_length;
    logic signed [31:0] curvature;
    logic               line_valid;
    logic               last_result;
  } out_t;

  // Coordinate difference and CORDIC datapath widths
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned CX_W    = 36;
  localparam int unsigned ANG_W   = 32;
  // Divider numerator width: |dh| * 16 plus rounding term
  localparam int unsigned NUM_W   = 38;
  localparam int unsigned DEN_W   = 32;

  // Angles in Q3.28 radians
  localparam logic signed [ANG_W-1:0] PI_Q28     = 32'sd843314857;
  localparam logic signed [33:0]      TWO_PI_Q28 = 34'sd1686629713;
  // 1/K in Q30
  localparam logic [29:0]             KINV_Q30   = 30'd652032874;
  // Floor of the mean segment length, 0.05 m in Q16.16
  localparam logic [31:0]             DS_FLOOR   = 32'd3277;
  localparam logic [31:0]             CURV_MAX   = 32'h7FFF_FFFF;

  // Step angle atan(2^-i) in Q3.28
  function automatic logic signed [ANG_W-1:0] step_angle(input logic [5:0] i);
    logic signed [ANG_W-1:0] a;
    a = '0;
    case (i)
      6'd0:  a = 32'sd210828714;
      6'd1:  a = 32'sd124459457;
      6'd2:  a = 32'sd65760959;
      6'd3:  a = 32'sd33381290;
      6'd4:  a = 32'sd16755422;
      6'd5:  a = 32'sd8385879;
      6'd6:  a = 32'sd4194033;
      6'd7:  a = 32'sd2097109;
      6'd8:  a = 32'sd1048571;
      6'd9:  a = 32'sd524287;
      6'd10: a = 32'sd262144;
      6'd11: a = 32'sd131072;
      default: begin
        if (i <= 6'd28) begin
          a = 32'sd1 <<< (6'd28 - i);
        end else begin
          a = '0;
        end
      end
    endcase
    return a;
  endfunction

endpackage

[rtl/polyline_curvature_estimator.sv]
// ----------------------------------------------------------------------------
// polyline_curvature_estimator
// Segment length and discrete curvature of a 2D polyline, one point per item.
// ----------------------------------------------------------------------------
// Each accepted point runs through a vectoring CORDIC (one micro-rotation
// per step), a split multiply for the length scale (low half, then high
// half), and from the third point on a restoring divider (one quotient
// bit per step) for the curvature; the first point of a line is only
// stored, or gives a short result if it is also the last. Input ready
// is low while an item is worked on. Results sit in a three-entry queue,
// so the next point is taken while earlier results still wait; a new
// batch of results waits until the queue has drained. Results lag by one
// point, the first result of a line comes with the third point, and the
// final point gives its own copy of the result before it.
module polyline_curvature_estimator #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pce_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pce_pkg::out_t   out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_MUL_LO, ST_MUL_HI, ST_ROUND, ST_PREP, ST_DIV, ST_PUSH
  } state_e;

  state_e              state_q;
  logic signed [31:0]  prev_x_q, prev_y_q, prev_hd_q;
  logic [31:0]         prev_seg_q, seg_q;
  logic [1:0]          ps_q;
  logic                head_done_q, last_q, neg_q;
  logic [63:0]         acc_q;
  pce_pkg::out_t       pend_q [3];
  logic [1:0]          pend_n_q;
  pce_pkg::out_t       res_q [3];
  logic [1:0]          cnt_q, rd_q;
  logic signed [31:0]  cur_x_q, cur_y_q;

  logic                                 in_acc, out_acc, cor_start, cor_done;
  logic signed [pce_pkg::DIFF_W-1:0]    dx, dy;
  logic signed [pce_pkg::CX_W-1:0]      mag;
  logic signed [pce_pkg::ANG_W-1:0]     ang;
  logic                                 div_start, div_done;
  logic [pce_pkg::NUM_W-1:0]            num, quot;
  logic [pce_pkg::DEN_W-1:0]            den;
  logic [63:0]                          rnd;
  logic [31:0]                          seg_d;
  logic signed [33:0]                   dh;
  logic [33:0]                          dh_abs;
  logic [32:0]                          ds_sum;
  logic [31:0]                          ds;
  logic [31:0]                          qsat, curv;
  pce_pkg::out_t                        short_res;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_data_o  = res_q[rd_q];

  // Start the CORDIC on the difference to the previous point
  assign dx        = pce_pkg::DIFF_W'(in_data_i.point_x) - pce_pkg::DIFF_W'(prev_x_q);
  assign dy        = pce_pkg::DIFF_W'(in_data_i.point_y) - pce_pkg::DIFF_W'(prev_y_q);
  assign cor_start = in_acc && (ps_q != 2'd0);

  pce_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .dx_i(dx), .dy_i(dy),
    .done_o(cor_done), .mag_o(mag), .ang_o(ang)
  );

  // Round the scaled magnitude and saturate
  always_comb begin
    rnd   = acc_q + 64'(1) * (64'd1 << 29);
    seg_d = (rnd[63:30] > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : rnd[61:30];
  end

  // Heading change wrap, mean length floor, divider operands
  always_comb begin
    dh = 34'(ang) - 34'(prev_hd_q);
    if (dh > 34'(pce_pkg::PI_Q28)) begin
      dh = dh - pce_pkg::TWO_PI_Q28;
    end else if (dh < -34'(pce_pkg::PI_Q28)) begin
      dh = dh + pce_pkg::TWO_PI_Q28;
    end
    dh_abs = dh[33] ? 34'(-dh) : 34'(dh);
    ds_sum = {1'b0, prev_seg_q} + {1'b0, seg_q};
    ds     = ds_sum[32:1];
    if (ds < pce_pkg::DS_FLOOR) begin
      ds = pce_pkg::DS_FLOOR;
    end
    num = {dh_abs, 4'b0000} + pce_pkg::NUM_W'(ds[31:1]);
    den = ds;
  end
  assign div_start = (state_q == ST_PREP);

  pce_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quot_o(quot)
  );

  // Saturate and sign the quotient
  always_comb begin
    qsat = (quot > pce_pkg::NUM_W'(pce_pkg::CURV_MAX)) ? pce_pkg::CURV_MAX : quot[31:0];
    curv = neg_q ? (32'd0 - qsat) : qsat;
    short_res = '{segment_length: '0, curvature: '0, line_valid: 1'b0,
                  last_result: 1'b1};
  end

  // Sequencer, line state and result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_hd_q   <= '0;
      prev_seg_q  <= '0;
      seg_q       <= '0;
      ps_q        <= '0;
      head_done_q <= 1'b0;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      pend_n_q    <= '0;
      cnt_q       <= '0;
      rd_q        <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      for (int k = 0; k < 3; k++) begin
        pend_q[k] <= '0;
        res_q[k]  <= '0;
      end
    end else begin
      // Drop a taken result
      if (out_acc) begin
        rd_q  <= rd_q + 1'b1;
        cnt_q <= cnt_q - 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cur_x_q <= in_data_i.point_x;
            cur_y_q <= in_data_i.point_y;
            last_q  <= in_data_i.last_point;
            if (ps_q == 2'd0) begin
              prev_x_q <= in_data_i.point_x;
              prev_y_q <= in_data_i.point_y;
              if (in_data_i.last_point) begin
                pend_q[0] <= short_res;
                pend_n_q  <= 2'd1;
                state_q   <= ST_PUSH;
              end else begin
                ps_q <= 2'd1;
              end
            end else begin
              state_q <= ST_CORDIC;
            end
          end
        end
        ST_CORDIC: begin
          if (cor_done) begin
            state_q <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          acc_q   <= 64'(mag[16:0]) * 64'(pce_pkg::KINV_Q30);
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          acc_q   <= acc_q + ((64'(mag[33:17]) * 64'(pce_pkg::KINV_Q30)) << 17);
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          seg_q <= seg_d;
          if (ps_q == 2'd1) begin
            if (last_q) begin
              ps_q      <= 2'd0;
              pend_q[0] <= short_res;
              pend_n_q  <= 2'd1;
              state_q   <= ST_PUSH;
            end else begin
              prev_seg_q  <= seg_d;
              prev_hd_q   <= ang;
              prev_x_q    <= cur_x_q;
              prev_y_q    <= cur_y_q;
              ps_q        <= 2'd2;
              head_done_q <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end else begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          neg_q   <= dh[33];
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            // Build the result list for this point
            if (!head_done_q) begin
              pend_q[0] <= '{segment_length: prev_seg_q, curvature: curv,
                             line_valid: 1'b1, last_result: 1'b0};
              pend_q[1] <= '{segment_length: seg_q, curvature: curv,
                             line_valid: 1'b1, last_result: 1'b0};
              pend_q[2] <= '{segment_length: seg_q, curvature: curv,
                             line_valid: 1'b1, last_result: 1'b1};
              pend_n_q  <= last_q ? 2'd3 : 2'd2;
            end else begin
              pend_q[0] <= '{segment_length: seg_q, curvature: curv,
                             line_valid: 1'b1, last_result: 1'b0};
              pend_q[1] <= '{segment_length: seg_q, curvature: curv,
                             line_valid: 1'b1, last_result: 1'b1};
              pend_n_q  <= last_q ? 2'd2 : 2'd1;
            end
            if (last_q) begin
              ps_q        <= 2'd0;
              head_done_q <= 1'b0;
            end else begin
              head_done_q <= 1'b1;
              prev_seg_q  <= seg_q;
              prev_hd_q   <= ang;
              prev_x_q    <= cur_x_q;
              prev_y_q    <= cur_y_q;
            end
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // Load the queue once it has drained
          if (cnt_q == 2'd0) begin
            res_q   <= pend_q;
            rd_q    <= '0;
            cnt_q   <= pend_n_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Queue never holds more than three results
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd3) else $error("result queue overflow");
  // A taken item after a line's first point closes the input until its work ends
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ps_q != 2'd0) |=> !in_ready_o) else $error("input open while busy");
  // Unit completions only in their own states
  a_cor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == ST_CORDIC) else $error("stray cordic done");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("stray divider done");

endmodule

[rtl/pce_cordic.sv]
// ----------------------------------------------------------------------------
// pce_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle on a shared
// add/shift datapath. Gives the scaled magnitude and the angle in Q3.28.
// ----------------------------------------------------------------------------
module pce_cordic #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [pce_pkg::DIFF_W-1:0]     dx_i,
  input  logic signed [pce_pkg::DIFF_W-1:0]     dy_i,
  output logic                                  done_o,
  output logic signed [pce_pkg::CX_W-1:0]       mag_o,
  output logic signed [pce_pkg::ANG_W-1:0]      ang_o
);

  localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);

  logic                                busy_q, done_q;
  logic [CW-1:0]                       i_q;
  logic signed [pce_pkg::CX_W-1:0]     x_q, y_q, xs, ys;
  logic signed [pce_pkg::ANG_W-1:0]    z_q, z0, da;
  logic signed [pce_pkg::CX_W-1:0]     x0, y0;

  // Turn a vector with negative x by pi
  always_comb begin
    x0 = pce_pkg::CX_W'(dx_i);
    y0 = pce_pkg::CX_W'(dy_i);
    z0 = '0;
    if (dx_i < 0) begin
      x0 = -x0;
      y0 = -y0;
      z0 = (dy_i >= 0) ? pce_pkg::PI_Q28 : -pce_pkg::PI_Q28;
    end
  end

  // Shared shift and step angle
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign da = pce_pkg::step_angle(6'(i_q));

  // Hold state and run one rotation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        x_q    <= x0;
        y_q    <= y0;
        z_q    <= z0;
      end else if (busy_q) begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + da;
        end else if (y_q < 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - da;
        end
        if (i_q == CW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign mag_o  = x_q;
  assign ang_o  = z_q;

  // No restart while a pass is running
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("cordic restarted while busy");
  // Done comes only at the end of a pass
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");
  // Magnitude is not negative at the end of a pass
  a_mag_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> x_q >= 0) else $error("cordic magnitude negative");

endmodule

[rtl/pce_divider.sv]
// ----------------------------------------------------------------------------
// pce_divider
// Restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pce_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pce_pkg::NUM_W-1:0]     num_i,
  input  logic [pce_pkg::DEN_W-1:0]     den_i,
  output logic                          done_o,
  output logic [pce_pkg::NUM_W-1:0]     quot_o
);

  localparam int unsigned CW = $clog2(pce_pkg::NUM_W + 1);

  logic                          busy_q, done_q;
  logic [CW-1:0]                 cnt_q;
  logic [pce_pkg::NUM_W-1:0]     nq_q;
  logic [pce_pkg::DEN_W-1:0]     rem_q, den_q;
  logic [pce_pkg::DEN_W:0]       trial, diff;
  logic                          qbit;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_q, nq_q[pce_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      nq_q   <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        nq_q   <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= qbit ? diff[pce_pkg::DEN_W-1:0] : trial[pce_pkg::DEN_W-1:0];
        nq_q  <= {nq_q[pce_pkg::NUM_W-2:0], qbit};
        if (cnt_q == CW'(pce_pkg::NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

  // No restart while dividing
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  // Remainder stays below the divisor
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q != '0) |-> rem_q < den_q) else $error("remainder too big");
  // Done follows a busy cycle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");

endmodule

[verif/polyline_curvature_estimator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_curvature_estimator_checker
// Watches both channels of the estimator, predicts each result from the
// accepted points, and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module polyline_curvature_estimator_checker #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  pce_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  pce_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam longint PI_L     = 843314857;
  localparam longint TWO_PI_L = 1686629713;
  localparam longint KINV_L   = 652032874;
  localparam longint FLOOR_L  = 3277;

  // Predictor state
  longint      last_x, last_y, last_heading;
  logic [31:0] last_len;
  int          pts_in_line;
  bit          head_sent;

  pce_pkg::out_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic longint arc_step(int i);
    longint tbl[12] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                        8385879, 4194033, 2097109, 1048571, 524287, 262144,
                        131072};
    if (i < 12) return tbl[i];
    if (i <= 28) return longint'(1) << (28 - i);
    return 0;
  endfunction

  // Vector length and heading of one segment
  task automatic measure_segment(input longint dx, input longint dy,
                                 output logic [31:0] len, output longint hd);
    longint x, y, z, xs, ys;
    logic [63:0] m;
    x = dx;
    y = dy;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arc_step(i);
      end else if (y < 0) begin
        x -= ys; y += xs; z -= arc_step(i);
      end
    end
    m = (64'(x) * 64'(KINV_L) + (64'd1 << 29)) >> 30;
    len = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
    hd = z;
  endtask

  function automatic logic [31:0] bend_rate(input longint dh,
                                            input logic [31:0] s0,
                                            input logic [31:0] s1);
    logic [63:0] ds, n, q;
    ds = (64'(s0) + 64'(s1)) >> 1;
    if (dh > PI_L) dh -= TWO_PI_L;
    else if (dh < -PI_L) dh += TWO_PI_L;
    if (ds < FLOOR_L) ds = FLOOR_L;
    n = 64'(dh < 0 ? -dh : dh) * 16;
    q = (n + (ds >> 1)) / ds;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return (dh < 0) ? -q[31:0] : q[31:0];
  endfunction

  function automatic pce_pkg::out_t make_result(logic [31:0] len, logic [31:0] curv,
                                                logic ok, logic fin);
    pce_pkg::out_t r;
    r.segment_length = len;
    r.curvature      = curv;
    r.line_valid     = ok;
    r.last_result    = fin;
    return r;
  endfunction

  task automatic predict_point(input pce_pkg::in_t p);
    longint x, y, hd;
    logic [31:0] seg, curv;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    if (pts_in_line == 0) begin
      last_x = x;
      last_y = y;
      if (p.last_point)
        expected_results.push_back(make_result(32'd0, 32'd0, 1'b0, 1'b1));
      else pts_in_line = 1;
      return;
    end
    measure_segment(x - last_x, y - last_y, seg, hd);
    if (pts_in_line == 1) begin
      if (p.last_point) begin
        pts_in_line = 0;
        expected_results.push_back(make_result(32'd0, 32'd0, 1'b0, 1'b1));
        return;
      end
      last_len = seg;
      last_heading = hd;
      last_x = x;
      last_y = y;
      pts_in_line = 2;
      head_sent = 0;
      return;
    end
    curv = bend_rate(hd - last_heading, last_len, seg);
    if (!head_sent) begin
      expected_results.push_back(make_result(last_len, curv, 1'b1, 1'b0));
      head_sent = 1;
    end
    expected_results.push_back(make_result(seg, curv, 1'b1, 1'b0));
    if (p.last_point) begin
      expected_results.push_back(make_result(seg, curv, 1'b1, 1'b1));
      pts_in_line = 0;
      head_sent = 0;
    end else begin
      last_len = seg;
      last_heading = hd;
      last_x = x;
      last_y = y;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Predict on accepted points, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    pce_pkg::out_t want;
    if (!rst_ni) begin
      pts_in_line  = 0;
      head_sent    = 0;
      last_x       = 0;
      last_y       = 0;
      last_heading = 0;
      last_len     = '0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_point(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.segment_length, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.segment_length !== want.segment_length)
            report_mismatch("segment_length", out_data_i.segment_length,
                            want.segment_length);
          if (out_data_i.curvature !== want.curvature)
            report_mismatch("curvature", out_data_i.curvature, want.curvature);
          if (out_data_i.line_valid !== want.line_valid)
            report_mismatch("line_valid", 32'(out_data_i.line_valid),
                            32'(want.line_valid));
          if (out_data_i.last_result !== want.last_result)
            report_mismatch("last_result", 32'(out_data_i.last_result),
                            32'(want.last_result));
        end
      end
    end
  end

endmodule

[verif/polyline_curvature_estimator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_curvature_estimator_test
// Drives polylines of random and extreme points into the estimator under
// several idling patterns and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module polyline_curvature_estimator_test;

  localparam int MAX_CYCLES = 400000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  pce_pkg::in_t  in_data;
  pce_pkg::out_t out_data;
  int   fail_count, pending;
  int   send_idle_pct, recv_stall_pct;
  bit   hold_off;
  longint cycles;
  int   sent;

  polyline_curvature_estimator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  polyline_curvature_estimator_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("polyline_curvature_estimator test failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom;
      default: return $signed($urandom_range(40 << 16)) - (20 <<< 16);
    endcase
  endfunction

  // Drop valid for one cycle
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one point and hold it until accepted
  task automatic send_point(input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic fin);
    while ($urandom_range(99) < send_idle_pct) idle_input();
    in_valid <= 1'b1;
    in_data  <= '{point_x: x, point_y: y, last_point: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // One polyline with random or extreme points
  task automatic send_line(input int npts);
    for (int i = 0; i < npts; i++)
      send_point(pick_coord(), pick_coord(), i == npts - 1);
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short lines, extremes, turns, zero segments
    send_point(0, 0, 1);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    send_point(32'sh8000_0000, 32'sh8000_0000, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    send_point(0, 0, 0);
    send_point(0, 0, 0);
    send_point(0, 0, 0);
    send_point(1, 0, 1);
    send_point(0, 0, 0);
    send_point(32'sh10000, 0, 0);
    send_point(32'sh10000, 32'sh10000, 0);
    send_point(0, 32'sh10000, 0);
    send_point(-32'sh10000, 0, 0);
    send_point(0, -32'sh1000, 0);
    send_point(32'sh800, 0, 1);

    // Random polylines over the idling phases, stressing stalls in between
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 65 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 65 : 0;
      if (ph == 3) begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(posedge clk);
            hold_off = 1'b0;
          end
          begin
            send_line(12);
            idle_input();
          end
        join
      end
      while (sent < 18 + (ph + 1) * 115)
        send_line($urandom_range(9) < 2 ? $urandom_range(1, 2) : $urandom_range(3, 12));
      // Let everything drain before the next phase
      idle_input();
      while (pending != 0) @(posedge clk);
    end

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("polyline_curvature_estimator test passed");
    end else begin
      $display("polyline_curvature_estimator test failed");
    end
    $finish;
  end

endmodule
